>>> hw/rtl/trtp_pkg.sv
package trtp_pkg;

   // Saturation limit of the tag and argument counters
   localparam int unsigned MAX_FIELDS = 64;
   localparam int unsigned COUNT_W =
      ($clog2(MAX_FIELDS + 1) > 7) ? $clog2(MAX_FIELDS + 1) : 7;
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_FIELDS);

   localparam int unsigned ID_W = 64;

   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_P      = 8'h70;
   localparam logic [7:0] CH_G      = 8'h67;

   typedef enum logic [2:0] {
      CLS_NONE  = 3'd0,
      CLS_DIR   = 3'd1,
      CLS_TAG   = 3'd2,
      CLS_NAME  = 3'd3,
      CLS_VALUE = 3'd4
   } class_type;

   typedef enum logic [1:0] {
      VERD_BUSY  = 2'd0,
      VERD_OK    = 2'd1,
      VERD_TRUNC = 2'd2,
      VERD_FAIL  = 2'd3
   } verdict_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last;
      logic [31:0] thread_id;
      logic [31:0] process_id;
      logic [31:0] parent_thread_id;
   } item_type;

   typedef struct packed {
      logic [7:0]             out_byte;
      class_type              byte_class;
      logic [5:0]             field_index;
      logic                   field_end;
      verdict_type            verdict;
      logic                   done_res;
      logic signed [ID_W-1:0] scope_id;
      logic [6:0]             tag_count;
      logic [6:0]             arg_count;
   } result_type;

endpackage

>>> hw/rtl/tracer_text_record_parser_unit.sv
// Byte-stream parser for text trace records of the form
// dir:scope:tag.tag:name=value,...: taking one byte per cycle and returning
// one result per byte. Each byte passes an input register, is classified
// combinationally against the per-record parse state, and lands in an output
// register, so a byte may be transferred every cycle; the only limit on rate
// is the downstream stall. The verdict on the byte marked last is final, and
// the parse state then returns to its start-of-record value for the next record.
module tracer_text_record_parser_unit (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last,
   input  logic [31:0]        req_thread_id,
   input  logic [31:0]        req_process_id,
   input  logic [31:0]        req_parent_thread_id,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic [2:0]         rsp_byte_class,
   output logic [5:0]         rsp_field_index,
   output logic               rsp_field_end,
   output logic [1:0]         rsp_verdict,
   output logic               rsp_done_res,
   output logic signed [63:0] rsp_scope_id,
   output logic [6:0]         rsp_tag_count,
   output logic [6:0]         rsp_arg_count
);

   trtp_pkg::item_type   req_item;
   trtp_pkg::item_type   item;
   trtp_pkg::result_type result;
   trtp_pkg::result_type rsp_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 item_valid;
   logic                 out_free;
   logic                 fire;

   assign req_item.data_byte        = req_data_byte;
   assign req_item.last             = req_last;
   assign req_item.thread_id        = req_thread_id;
   assign req_item.process_id       = req_process_id;
   assign req_item.parent_thread_id = req_parent_thread_id;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign fire         = item_valid && out_free;
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   trtp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (out_free),
      .item_valid (item_valid),
      .item       (item)
   );

   trtp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the result while the consumer stalls
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_ff.out_byte;
   assign rsp_byte_class  = rsp_ff.byte_class;
   assign rsp_field_index = rsp_ff.field_index;
   assign rsp_field_end   = rsp_ff.field_end;
   assign rsp_verdict     = rsp_ff.verdict;
   assign rsp_done_res    = rsp_ff.done_res;
   assign rsp_scope_id    = rsp_ff.scope_id;
   assign rsp_tag_count   = rsp_ff.tag_count;
   assign rsp_arg_count   = rsp_ff.arg_count;

endmodule

>>> hw/rtl/trtp_in_stage.sv
module trtp_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  trtp_pkg::item_type req_item,
   input  logic              advance,
   output logic              item_valid,
   output trtp_pkg::item_type item
);

   logic               valid_ff;
   logic               valid_in;
   trtp_pkg::item_type item_ff;
   logic               take;

   // hold while the parsed result cannot move on
   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign valid_in  = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> hw/rtl/trtp_core.sv
module trtp_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  trtp_pkg::item_type   item,
   output trtp_pkg::result_type result
);

   typedef enum logic [3:0] {
      PH_DIR        = 4'd0,
      PH_COLON      = 4'd1,
      PH_SCOPE      = 4'd2,
      PH_SCOPE_P    = 4'd3,
      PH_NUM        = 4'd4,
      PH_TAGS_FIRST = 4'd5,
      PH_TAG_NEW    = 4'd6,
      PH_TAG        = 4'd7,
      PH_ARGS_FIRST = 4'd8,
      PH_NAME_NEW   = 4'd9,
      PH_NAME       = 4'd10,
      PH_VALUE      = 4'd11,
      PH_DONE       = 4'd12
   } phase_type;

   localparam int unsigned CW = trtp_pkg::COUNT_W;
   localparam int unsigned IW = trtp_pkg::ID_W;

   phase_type             phase_ff, phase_in;
   logic                  esc_ff, esc_in;
   logic                  skip_ff, skip_in;
   logic                  neg_ff, neg_in;
   logic signed [IW-1:0]  acc_ff, acc_in;
   logic [CW-1:0]         tag_ff, tag_in;
   logic [CW-1:0]         arg_ff, arg_in;
   logic [7:0]            prev_ff, prev_in;
   trtp_pkg::verdict_type verd_ff, verd_in;

   logic [7:0]            b;
   logic                  is_digit;
   logic signed [IW-1:0]  digit_ext;
   trtp_pkg::class_type   cls;
   trtp_pkg::class_type   kind;
   logic                  fend;
   logic                  dropped;
   logic                  fail;
   logic                  field_go;
   logic [CW-1:0]         fidx_wide;
   trtp_pkg::verdict_type verd_out;

   assign b        = item.data_byte;
   assign is_digit = (b >= trtp_pkg::CH_ZERO) && (b <= trtp_pkg::CH_NINE);

   // the accumulator holds the signed id, so a minus sign folds into the digit
   assign digit_ext = neg_ff ? -$signed({{(IW-4){1'b0}}, b[3:0]})
                             :  $signed({{(IW-4){1'b0}}, b[3:0]});

   always_comb begin
      phase_in = phase_ff;
      esc_in   = esc_ff;
      skip_in  = skip_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      tag_in   = tag_ff;
      arg_in   = arg_ff;
      verd_in  = verd_ff;
      cls      = trtp_pkg::CLS_NONE;
      kind     = trtp_pkg::CLS_TAG;
      fend     = 1'b0;
      dropped  = 1'b0;
      fail     = 1'b0;
      field_go = 1'b0;

      unique case (phase_ff)
         PH_DIR: begin
            if (b == trtp_pkg::CH_GT || b == trtp_pkg::CH_LT) begin
               cls      = trtp_pkg::CLS_DIR;
               phase_in = PH_COLON;
            end else begin
               fail = 1'b1;
            end
         end
         PH_COLON: begin
            if (b == trtp_pkg::CH_COLON) begin
               phase_in = PH_SCOPE;
            end else begin
               fail = 1'b1;
            end
         end
         PH_SCOPE: begin
            priority if (b == trtp_pkg::CH_T) begin
               acc_in   = $signed({32'b0, item.thread_id});
               skip_in  = 1'b1;
               phase_in = PH_TAGS_FIRST;
            end else if (b == trtp_pkg::CH_G) begin
               acc_in   = '0;
               skip_in  = 1'b1;
               phase_in = PH_TAGS_FIRST;
            end else if (b == trtp_pkg::CH_P) begin
               acc_in   = $signed({32'b0, item.process_id});
               phase_in = PH_SCOPE_P;
            end else if (b == trtp_pkg::CH_COLON) begin
               acc_in   = '0;
               phase_in = PH_TAGS_FIRST;
            end else if (b == trtp_pkg::CH_MINUS) begin
               neg_in   = 1'b1;
               phase_in = PH_NUM;
            end else if (is_digit) begin
               acc_in   = $signed({{(IW-4){1'b0}}, b[3:0]});
               phase_in = PH_NUM;
            end else begin
               fail = 1'b1;
            end
         end
         PH_SCOPE_P: begin
            if (b == trtp_pkg::CH_P) begin
               acc_in  = $signed({32'b0, item.parent_thread_id});
               skip_in = 1'b1;
            end
            phase_in = PH_TAGS_FIRST;
         end
         PH_NUM: begin
            priority if (is_digit) begin
               acc_in = (acc_ff <<< 3) + (acc_ff <<< 1) + digit_ext;
            end else if (b == trtp_pkg::CH_COLON) begin
               phase_in = PH_TAGS_FIRST;
            end else begin
               fail = 1'b1;
            end
         end
         PH_TAGS_FIRST: begin
            priority if (skip_ff) begin
               skip_in = 1'b0;
            end else if (b == trtp_pkg::CH_COLON) begin
               phase_in = PH_ARGS_FIRST;
            end else begin
               tag_in   = (tag_ff < trtp_pkg::MAX_COUNT) ? tag_ff + 1'b1 : tag_ff;
               phase_in = PH_TAG;
               field_go = 1'b1;
            end
         end
         PH_TAG_NEW: begin
            tag_in   = (tag_ff < trtp_pkg::MAX_COUNT) ? tag_ff + 1'b1 : tag_ff;
            phase_in = PH_TAG;
            field_go = 1'b1;
         end
         PH_TAG: begin
            field_go = 1'b1;
         end
         PH_ARGS_FIRST: begin
            if (b == trtp_pkg::CH_COLON) begin
               verd_in  = trtp_pkg::VERD_OK;
               phase_in = PH_DONE;
            end else begin
               arg_in   = (arg_ff < trtp_pkg::MAX_COUNT) ? arg_ff + 1'b1 : arg_ff;
               phase_in = PH_NAME;
               kind     = trtp_pkg::CLS_NAME;
               field_go = 1'b1;
            end
         end
         PH_NAME_NEW: begin
            arg_in   = (arg_ff < trtp_pkg::MAX_COUNT) ? arg_ff + 1'b1 : arg_ff;
            phase_in = PH_NAME;
            kind     = trtp_pkg::CLS_NAME;
            field_go = 1'b1;
         end
         PH_NAME: begin
            kind     = trtp_pkg::CLS_NAME;
            field_go = 1'b1;
         end
         PH_VALUE: begin
            kind     = trtp_pkg::CLS_VALUE;
            field_go = 1'b1;
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase

      // body byte of a tag, name or value
      if (field_go) begin
         priority if (esc_ff) begin
            esc_in = 1'b0;
            cls    = kind;
         end else if (b == trtp_pkg::CH_BSLASH) begin
            esc_in  = 1'b1;
            dropped = 1'b1;
         end else if (kind == trtp_pkg::CLS_TAG) begin
            priority if (b == trtp_pkg::CH_DOT) begin
               fend     = 1'b1;
               phase_in = PH_TAG_NEW;
            end else if (b == trtp_pkg::CH_COLON) begin
               fend     = 1'b1;
               phase_in = PH_ARGS_FIRST;
            end else if (b == trtp_pkg::CH_GT || b == trtp_pkg::CH_LT ||
                         b == trtp_pkg::CH_EQ || b == trtp_pkg::CH_NL) begin
               fail = 1'b1;
            end else begin
               cls = trtp_pkg::CLS_TAG;
            end
         end else if (kind == trtp_pkg::CLS_NAME) begin
            priority if (b == trtp_pkg::CH_EQ) begin
               fend     = 1'b1;
               phase_in = PH_VALUE;
            end else if (b == trtp_pkg::CH_GT || b == trtp_pkg::CH_LT ||
                         b == trtp_pkg::CH_NL) begin
               fail = 1'b1;
            end else begin
               cls = trtp_pkg::CLS_NAME;
            end
         end else begin
            priority if (b == trtp_pkg::CH_COMMA || b == trtp_pkg::CH_EQ) begin
               fend     = 1'b1;
               phase_in = PH_NAME_NEW;
            end else if (b == trtp_pkg::CH_COLON) begin
               fend     = 1'b1;
               verd_in  = trtp_pkg::VERD_OK;
               phase_in = PH_DONE;
            end else begin
               cls = trtp_pkg::CLS_VALUE;
            end
         end
      end

      if (fail) begin
         verd_in  = trtp_pkg::VERD_FAIL;
         phase_in = PH_DONE;
      end
   end

   assign prev_in = dropped ? prev_ff : b;

   always_comb begin
      if (arg_in != '0) begin
         fidx_wide = arg_in - 1'b1;
      end else if (tag_in != '0) begin
         fidx_wide = tag_in - 1'b1;
      end else begin
         fidx_wide = '0;
      end
   end

   // an open name whose last taken byte is a colon cannot be a clean truncation
   always_comb begin
      verd_out = verd_in;
      if (item.last && verd_in == trtp_pkg::VERD_BUSY) begin
         verd_out = (phase_in == PH_NAME && prev_in == trtp_pkg::CH_COLON)
                    ? trtp_pkg::VERD_FAIL : trtp_pkg::VERD_TRUNC;
      end
   end

   always_comb begin
      result.out_byte    = dropped ? 8'd0 : b;
      result.byte_class  = cls;
      result.field_index = fidx_wide[5:0];
      result.field_end   = fend;
      result.verdict     = verd_out;
      result.done_res    = item.last;
      result.scope_id    = acc_in;
      result.tag_count   = tag_in[6:0];
      result.arg_count   = arg_in[6:0];
   end

   // advance on each transfer; the last byte returns the record state to reset
   always_ff @(posedge clock) begin
      if (reset || (fire && item.last)) begin
         phase_ff <= PH_DIR;
         esc_ff   <= 1'b0;
         skip_ff  <= 1'b0;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
         tag_ff   <= '0;
         arg_ff   <= '0;
         prev_ff  <= 8'd0;
         verd_ff  <= trtp_pkg::VERD_BUSY;
      end else if (fire) begin
         phase_ff <= phase_in;
         esc_ff   <= esc_in;
         skip_ff  <= skip_in;
         neg_ff   <= neg_in;
         acc_ff   <= acc_in;
         tag_ff   <= tag_in;
         arg_ff   <= arg_in;
         prev_ff  <= prev_in;
         verd_ff  <= verd_in;
      end
   end

endmodule

>>> dv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [3:0] {
      ST_DIR, ST_COLON, ST_SCOPE, ST_SCOPE_P, ST_NUM, ST_TAGS_FIRST, ST_TAG_NEW, ST_TAG,
      ST_ARGS_FIRST, ST_NAME_NEW, ST_NAME, ST_VALUE, ST_DONE
   } parse_state_type;

   typedef struct {
      logic [7:0]           data;
      logic                 fin;
      logic [31:0]          tid;
      logic [31:0]          pid;
      logic [31:0]          ptid;
      bit                   pinned;
      trtp_pkg::result_type res;
   } stim_row_type;

   localparam int RANDOM_ITEMS = 800;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_LIMIT  = 20000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [7:0]         req_data_byte;
   logic               req_last;
   logic [31:0]        req_thread_id;
   logic [31:0]        req_process_id;
   logic [31:0]        req_parent_thread_id;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [7:0]         rsp_out_byte;
   logic [2:0]         rsp_byte_class;
   logic [5:0]         rsp_field_index;
   logic               rsp_field_end;
   logic [1:0]         rsp_verdict;
   logic               rsp_done_res;
   logic signed [63:0] rsp_scope_id;
   logic [6:0]         rsp_tag_count;
   logic [6:0]         rsp_arg_count;

   // parser state as predicted
   parse_state_type              ps;
   logic                         esc_pend;
   logic                         skip_pend;
   logic                         neg_id;
   logic [63:0]                  id_acc;
   logic [trtp_pkg::COUNT_W-1:0] n_tags;
   logic [trtp_pkg::COUNT_W-1:0] n_args;
   logic [7:0]                   prev_b;
   trtp_pkg::verdict_type        verd;

   trtp_pkg::result_type expected_q[$];
   stim_row_type         dir_rows[$];
   logic [7:0]           rec_q[$];
   int                   errors = 0;
   int                   items_sent = 0;
   bit                   tx_quiet = 0;
   bit                   rx_quiet = 0;
   bit                   hold_req = 0;
   bit                   pinned_on = 0;
   trtp_pkg::result_type pinned_res = '0;

   tracer_text_record_parser_unit DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .req_last             (req_last),
      .req_thread_id        (req_thread_id),
      .req_process_id       (req_process_id),
      .req_parent_thread_id (req_parent_thread_id),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_byte_class       (rsp_byte_class),
      .rsp_field_index      (rsp_field_index),
      .rsp_field_end        (rsp_field_end),
      .rsp_verdict          (rsp_verdict),
      .rsp_done_res         (rsp_done_res),
      .rsp_scope_id         (rsp_scope_id),
      .rsp_tag_count        (rsp_tag_count),
      .rsp_arg_count        (rsp_arg_count)
   );

   always #5 clock = ~clock;

   // ---------------- predictor ----------------

   task automatic clear_parse();
      ps        = ST_DIR;
      esc_pend  = 1'b0;
      skip_pend = 1'b0;
      neg_id    = 1'b0;
      id_acc    = '0;
      n_tags    = '0;
      n_args    = '0;
      prev_b    = '0;
      verd      = trtp_pkg::VERD_BUSY;
   endtask

   task automatic mark_failed();
      verd = trtp_pkg::VERD_FAIL;
      ps   = ST_DONE;
   endtask

   function automatic logic [trtp_pkg::COUNT_W-1:0] bump(
         input logic [trtp_pkg::COUNT_W-1:0] c);
      return (c < trtp_pkg::MAX_COUNT) ? c + 1'b1 : c;
   endfunction

   task automatic take_field(input trtp_pkg::class_type kind, input logic [7:0] b,
                             inout trtp_pkg::class_type cls, inout logic fend,
                             inout logic dropped);
      if (esc_pend) begin
         esc_pend = 1'b0;
         cls = kind;
      end else if (b == trtp_pkg::CH_BSLASH) begin
         esc_pend = 1'b1;
         dropped = 1'b1;
      end else begin
         case (kind)
            trtp_pkg::CLS_TAG: begin
               if (b == trtp_pkg::CH_DOT) begin
                  fend = 1'b1;
                  ps = ST_TAG_NEW;
               end else if (b == trtp_pkg::CH_COLON) begin
                  fend = 1'b1;
                  ps = ST_ARGS_FIRST;
               end else if (b == trtp_pkg::CH_GT || b == trtp_pkg::CH_LT ||
                            b == trtp_pkg::CH_EQ || b == trtp_pkg::CH_NL) begin
                  mark_failed();
               end else begin
                  cls = trtp_pkg::CLS_TAG;
               end
            end
            trtp_pkg::CLS_NAME: begin
               if (b == trtp_pkg::CH_EQ) begin
                  fend = 1'b1;
                  ps = ST_VALUE;
               end else if (b == trtp_pkg::CH_GT || b == trtp_pkg::CH_LT ||
                            b == trtp_pkg::CH_NL) begin
                  mark_failed();
               end else begin
                  cls = trtp_pkg::CLS_NAME;
               end
            end
            default: begin
               if (b == trtp_pkg::CH_COMMA || b == trtp_pkg::CH_EQ) begin
                  fend = 1'b1;
                  ps = ST_NAME_NEW;
               end else if (b == trtp_pkg::CH_COLON) begin
                  fend = 1'b1;
                  verd = trtp_pkg::VERD_OK;
                  ps = ST_DONE;
               end else begin
                  cls = trtp_pkg::CLS_VALUE;
               end
            end
         endcase
      end
   endtask

   task automatic parse_byte(input trtp_pkg::item_type it, output trtp_pkg::result_type r);
      logic [7:0]                   b;
      trtp_pkg::class_type          cls;
      logic                         fend;
      logic                         dropped;
      logic [trtp_pkg::COUNT_W-1:0] fidx;
      b = it.data_byte;
      cls = trtp_pkg::CLS_NONE;
      fend = 1'b0;
      dropped = 1'b0;
      case (ps)
         ST_DIR: begin
            if (b == trtp_pkg::CH_GT || b == trtp_pkg::CH_LT) begin
               cls = trtp_pkg::CLS_DIR;
               ps = ST_COLON;
            end else begin
               mark_failed();
            end
         end
         ST_COLON: begin
            if (b == trtp_pkg::CH_COLON) ps = ST_SCOPE;
            else mark_failed();
         end
         ST_SCOPE: begin
            if (b == trtp_pkg::CH_T) begin
               id_acc = 64'(it.thread_id);
               skip_pend = 1'b1;
               ps = ST_TAGS_FIRST;
            end else if (b == trtp_pkg::CH_G) begin
               id_acc = '0;
               skip_pend = 1'b1;
               ps = ST_TAGS_FIRST;
            end else if (b == trtp_pkg::CH_P) begin
               id_acc = 64'(it.process_id);
               ps = ST_SCOPE_P;
            end else if (b == trtp_pkg::CH_COLON) begin
               id_acc = '0;
               ps = ST_TAGS_FIRST;
            end else if (b == trtp_pkg::CH_MINUS) begin
               neg_id = 1'b1;
               ps = ST_NUM;
            end else if (b >= trtp_pkg::CH_ZERO && b <= trtp_pkg::CH_NINE) begin
               id_acc = 64'(b - trtp_pkg::CH_ZERO);
               ps = ST_NUM;
            end else begin
               mark_failed();
            end
         end
         ST_SCOPE_P: begin
            if (b == trtp_pkg::CH_P) begin
               id_acc = 64'(it.parent_thread_id);
               skip_pend = 1'b1;
            end
            ps = ST_TAGS_FIRST;
         end
         ST_NUM: begin
            if (b >= trtp_pkg::CH_ZERO && b <= trtp_pkg::CH_NINE)
               id_acc = id_acc * 64'd10 + 64'(b - trtp_pkg::CH_ZERO);
            else if (b == trtp_pkg::CH_COLON) ps = ST_TAGS_FIRST;
            else mark_failed();
         end
         ST_TAGS_FIRST: begin
            if (skip_pend) begin
               skip_pend = 1'b0;
            end else if (b == trtp_pkg::CH_COLON) begin
               ps = ST_ARGS_FIRST;
            end else begin
               n_tags = bump(n_tags);
               ps = ST_TAG;
               take_field(trtp_pkg::CLS_TAG, b, cls, fend, dropped);
            end
         end
         ST_TAG_NEW: begin
            n_tags = bump(n_tags);
            ps = ST_TAG;
            take_field(trtp_pkg::CLS_TAG, b, cls, fend, dropped);
         end
         ST_TAG: take_field(trtp_pkg::CLS_TAG, b, cls, fend, dropped);
         ST_ARGS_FIRST: begin
            if (b == trtp_pkg::CH_COLON) begin
               verd = trtp_pkg::VERD_OK;
               ps = ST_DONE;
            end else begin
               n_args = bump(n_args);
               ps = ST_NAME;
               take_field(trtp_pkg::CLS_NAME, b, cls, fend, dropped);
            end
         end
         ST_NAME_NEW: begin
            n_args = bump(n_args);
            ps = ST_NAME;
            take_field(trtp_pkg::CLS_NAME, b, cls, fend, dropped);
         end
         ST_NAME:  take_field(trtp_pkg::CLS_NAME, b, cls, fend, dropped);
         ST_VALUE: take_field(trtp_pkg::CLS_VALUE, b, cls, fend, dropped);
         default:  ps = ST_DONE;
      endcase

      if (!dropped) prev_b = b;

      if (n_args != 0) fidx = n_args - 1'b1;
      else if (n_tags != 0) fidx = n_tags - 1'b1;
      else fidx = '0;

      r.verdict = verd;
      if (it.last && verd == trtp_pkg::VERD_BUSY) begin
         // a name cut off right after a colon counts as broken
         if (ps == ST_NAME && prev_b == trtp_pkg::CH_COLON) r.verdict = trtp_pkg::VERD_FAIL;
         else r.verdict = trtp_pkg::VERD_TRUNC;
      end
      r.out_byte    = dropped ? 8'h00 : b;
      r.byte_class  = cls;
      r.field_index = fidx[5:0];
      r.field_end   = fend;
      r.done_res    = it.last;
      r.scope_id    = neg_id ? 64'd0 - id_acc : id_acc;
      r.tag_count   = n_tags[6:0];
      r.arg_count   = n_args[6:0];

      if (it.last) clear_parse();
   endtask

   // ---------------- checking ----------------

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      trtp_pkg::item_type   seen_item;
      trtp_pkg::result_type want_r;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, got byte %0h",
                        $time, rsp_out_byte);
            end else begin
               want_r = expected_q.pop_front();
               check_field("out_byte", 64'(want_r.out_byte), 64'(rsp_out_byte));
               check_field("byte_class", 64'(want_r.byte_class), 64'(rsp_byte_class));
               check_field("field_index", 64'(want_r.field_index), 64'(rsp_field_index));
               check_field("field_end", 64'(want_r.field_end), 64'(rsp_field_end));
               check_field("verdict", 64'(want_r.verdict), 64'(rsp_verdict));
               check_field("done_res", 64'(want_r.done_res), 64'(rsp_done_res));
               check_field("scope_id", 64'(want_r.scope_id), 64'(rsp_scope_id));
               check_field("tag_count", 64'(want_r.tag_count), 64'(rsp_tag_count));
               check_field("arg_count", 64'(want_r.arg_count), 64'(rsp_arg_count));
            end
         end
         if (req_valid && !req_stall) begin
            seen_item.data_byte        = req_data_byte;
            seen_item.last             = req_last;
            seen_item.thread_id        = req_thread_id;
            seen_item.process_id       = req_process_id;
            seen_item.parent_thread_id = req_parent_thread_id;
            parse_byte(seen_item, want_r);
            if (pinned_on) want_r = pinned_res;
            expected_q = {expected_q, want_r};
         end
      end
   end

   // ---------------- stimulus helpers ----------------

   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [31:0] id_word();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [7:0] pick_special();
      case ($urandom_range(0, 9))
         0:       return trtp_pkg::CH_GT;
         1:       return trtp_pkg::CH_LT;
         2:       return trtp_pkg::CH_EQ;
         3:       return trtp_pkg::CH_DOT;
         4:       return trtp_pkg::CH_COLON;
         5:       return trtp_pkg::CH_BSLASH;
         6:       return trtp_pkg::CH_NL;
         7:       return trtp_pkg::CH_COMMA;
         8:       return trtp_pkg::CH_MINUS;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic trtp_pkg::result_type res_of(input logic [7:0] b,
                                                   input trtp_pkg::class_type cls,
                                                   input trtp_pkg::verdict_type v,
                                                   input logic [63:0] sid);
      trtp_pkg::result_type r;
      r = '0;
      r.out_byte   = b;
      r.byte_class = cls;
      r.verdict    = v;
      r.done_res   = 1'b1;
      r.scope_id   = sid;
      return r;
   endfunction

   task automatic add_row(input logic [7:0] b, input logic fin, input logic [31:0] tid,
                          input logic [31:0] pid, input logic [31:0] ptid,
                          input bit pin, input trtp_pkg::result_type res);
      stim_row_type row;
      row.data = b;
      row.fin = fin;
      row.tid = tid;
      row.pid = pid;
      row.ptid = ptid;
      row.pinned = pin;
      row.res = res;
      dir_rows = {dir_rows, row};
   endtask

   task automatic send_byte(input logic [7:0] b, input logic fin, input logic [31:0] tid,
                            input logic [31:0] pid, input logic [31:0] ptid,
                            input bit pin, input trtp_pkg::result_type res);
      int gap;
      gap = tx_quiet ? 0 : idle_len();
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid            = 1'b1;
      req_data_byte        = b;
      req_last             = fin;
      req_thread_id        = tid;
      req_process_id       = pid;
      req_parent_thread_id = ptid;
      pinned_on            = pin;
      pinned_res           = res;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic rec_add(input logic [7:0] b);
      rec_q = {rec_q, b};
   endtask

   task automatic push_field(input int len);
      int pick;
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            rec_add(8'h61 + 8'($urandom_range(0, 25)));
         end else if (pick < 85) begin
            rec_add(8'($urandom_range(0, 255)));
         end else begin
            rec_add(trtp_pkg::CH_BSLASH);
            rec_add(pick_special());
         end
      end
   endtask

   // byte after a scope letter, normally the colon
   function automatic logic [7:0] scope_tail();
      return ($urandom_range(0, 4) != 0) ? trtp_pkg::CH_COLON : 8'($urandom_range(0, 255));
   endfunction

   task automatic build_record(input bit sat, input bit stop_in_name);
      int n_t;
      int n_a;
      rec_q.delete();
      rec_add($urandom_range(0, 1) ? trtp_pkg::CH_GT : trtp_pkg::CH_LT);
      rec_add(trtp_pkg::CH_COLON);
      case ($urandom_range(0, 5))
         0: begin
            rec_add(trtp_pkg::CH_T);
            rec_add(scope_tail());
         end
         1: begin
            rec_add(trtp_pkg::CH_P);
            rec_add(scope_tail());
         end
         2: begin
            rec_add(trtp_pkg::CH_P);
            rec_add(trtp_pkg::CH_P);
            rec_add(scope_tail());
         end
         3: begin
            rec_add(trtp_pkg::CH_G);
            rec_add(scope_tail());
         end
         4: rec_add(trtp_pkg::CH_COLON);
         default: begin
            if ($urandom_range(0, 1)) rec_add(trtp_pkg::CH_MINUS);
            repeat ($urandom_range(1, 24))
               rec_add(trtp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            rec_add(trtp_pkg::CH_COLON);
         end
      endcase

      n_t = sat ? $urandom_range(65, 70) : $urandom_range(0, 4);
      if (n_t == 0) rec_add(trtp_pkg::CH_COLON);
      for (int i = 0; i < n_t; i++) begin
         push_field(sat ? 1 : $urandom_range(1, 6));
         rec_add((i == n_t - 1) ? trtp_pkg::CH_COLON : trtp_pkg::CH_DOT);
      end

      n_a = sat ? $urandom_range(65, 70) : $urandom_range(stop_in_name, 4);
      if (n_a == 0) rec_add(trtp_pkg::CH_COLON);
      for (int i = 0; i < n_a; i++) begin
         push_field(sat ? 1 : $urandom_range(1, 5));
         if (stop_in_name) begin
            // end the record on a colon inside the name
            if ($urandom_range(0, 1)) rec_add(trtp_pkg::CH_BSLASH);
            rec_add(trtp_pkg::CH_COLON);
            return;
         end
         rec_add(trtp_pkg::CH_EQ);
         push_field(sat ? 1 : $urandom_range(0, 5));
         if (i == n_a - 1) rec_add(trtp_pkg::CH_COLON);
         else rec_add($urandom_range(0, 3) ? trtp_pkg::CH_COMMA : trtp_pkg::CH_EQ);
      end

      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 3)) rec_add(8'($urandom_range(0, 255)));
   endtask

   task automatic send_record();
      for (int i = 0; i < rec_q.size(); i++)
         send_byte(rec_q[i], i == rec_q.size() - 1, id_word(), id_word(), id_word(), 0, '0);
   endtask

   // drop valid first so the last transfer is not offered again
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   // ---------------- receiver ----------------

   initial begin : receiver
      int run_left;
      int held;
      rsp_stall = 1'b0;
      run_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_stall = 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++) @(negedge clock);
            hold_req = 0;
         end
         if (run_left > 0) begin
            run_left--;
            rsp_stall = 1'b1;
         end else if (rx_quiet) begin
            rsp_stall = 1'b0;
         end else begin
            run_left = idle_len();
            rsp_stall = (run_left != 0);
            if (run_left != 0) run_left--;
         end
      end
   end

   // ---------------- main sequence ----------------

   initial begin : stimulus
      int  pick;
      int  cut;
      int  target;
      int  drain;
      bit  paused;
      clock                = 1'b0;
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_data_byte        = '0;
      req_last             = 1'b0;
      req_thread_id        = '0;
      req_process_id       = '0;
      req_parent_thread_id = '0;
      paused               = 0;
      clear_parse();

      // bad start byte
      add_row(8'h78, 1, 0, 0, 0, 1,
              res_of(8'h78, trtp_pkg::CLS_NONE, trtp_pkg::VERD_FAIL, 64'd0));
      // early end after direction
      add_row(trtp_pkg::CH_GT, 1, 32'hFFFF_FFFF, 0, 0, 1,
              res_of(trtp_pkg::CH_GT, trtp_pkg::CLS_DIR, trtp_pkg::VERD_TRUNC, 64'd0));
      // bad byte in a numeric scope
      add_row(trtp_pkg::CH_LT, 0, 0, 0, 0, 0, '0);
      add_row(trtp_pkg::CH_COLON, 0, 0, 0, 0, 0, '0);
      add_row(8'h39, 0, 0, 0, 0, 0, '0);
      add_row(8'hFF, 1, 0, 0, 0, 1,
              res_of(8'hFF, trtp_pkg::CLS_NONE, trtp_pkg::VERD_FAIL, 64'd9));
      // pp scope, escaped '=' in a tag, name ending on a colon
      add_row(trtp_pkg::CH_GT, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, '0);
      add_row(trtp_pkg::CH_COLON, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, '0);
      add_row(trtp_pkg::CH_P, 0, 0, 32'hFFFF_FFFF, 32'h0000_0000, 0, '0);
      add_row(trtp_pkg::CH_P, 0, 0, 32'h0000_0000, 32'hFFFF_FFFF, 0, '0);
      add_row(trtp_pkg::CH_COLON, 0, 0, 0, 0, 0, '0);
      add_row(8'h00, 0, 0, 0, 0, 0, '0);
      add_row(trtp_pkg::CH_BSLASH, 0, 0, 0, 0, 0, '0);
      add_row(trtp_pkg::CH_EQ, 0, 0, 0, 0, 0, '0);
      add_row(trtp_pkg::CH_DOT, 0, 0, 0, 0, 0, '0);
      add_row(trtp_pkg::CH_COLON, 0, 0, 0, 0, 0, '0);
      add_row(8'h6E, 0, 0, 0, 0, 0, '0);
      add_row(trtp_pkg::CH_COLON, 1, 0, 0, 0, 0, '0);
      // negative id, no tags, no arguments, then a byte after the verdict
      add_row(trtp_pkg::CH_GT, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, '0);
      add_row(trtp_pkg::CH_COLON, 0, 0, 0, 0, 0, '0);
      add_row(trtp_pkg::CH_MINUS, 0, 0, 0, 0, 0, '0);
      add_row(8'h31, 0, 0, 0, 0, 0, '0);
      add_row(trtp_pkg::CH_COLON, 0, 0, 0, 0, 0, '0);
      add_row(trtp_pkg::CH_COLON, 0, 0, 0, 0, 0, '0);
      add_row(trtp_pkg::CH_COLON, 0, 0, 0, 0, 0, '0);
      add_row(8'h71, 1, 0, 0, 0, 0, '0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i])
         send_byte(dir_rows[i].data, dir_rows[i].fin, dir_rows[i].tid, dir_rows[i].pid,
                   dir_rows[i].ptid, dir_rows[i].pinned, dir_rows[i].res);
      wait_drained();

      // back-pressure: hold the receiver while a saturating record streams in
      tx_quiet = 1;
      hold_req = 1;
      build_record(1, 0);
      send_record();
      tx_quiet = 0;
      wait_drained();

      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         tx_quiet = ($urandom_range(0, 5) == 0);
         rx_quiet = ($urandom_range(0, 5) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            rec_q.delete();
            repeat ($urandom_range(1, 8)) rec_add(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 2) == 0)
               rec_q[0] = $urandom_range(0, 1) ? trtp_pkg::CH_GT : trtp_pkg::CH_LT;
         end else if (pick < 15) begin
            build_record(0, 1);
         end else begin
            build_record(pick < 17, 0);
            if (pick >= 17 && pick < 32) begin
               cut = $urandom_range(1, rec_q.size());
               rec_q = rec_q[0:cut-1];
            end else if (pick >= 32 && pick < 44) begin
               rec_q[$urandom_range(0, rec_q.size() - 1)] = pick_special();
            end
         end
         send_record();
         if (!paused && items_sent > target - RANDOM_ITEMS / 2) begin
            paused = 1;
            wait_drained();
         end
      end
      rx_quiet = 0;

      @(negedge clock);
      req_valid = 1'b0;
      pinned_on = 0;

      drain = 0;
      while (expected_q.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      if (expected_q.size() != 0) begin
         errors++;
         $display("%0t: results missing, expected %0d more, got none", $time,
                  expected_q.size());
      end
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(20_000_000);
      $display("Verification failed");
      $finish;
   end

endmodule
